### hdl/bpa_pkg.sv
// Shared types, codes and helpers for the buddy page allocator.
`default_nettype none

package bpa_pkg;

   localparam int unsigned PAGES_DEFAULT = 1024;

   // request kinds
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NO_SPACE  = 2'd1,
      STAT_BAD_SIZE  = 2'd2,
      STAT_NOT_ALLOC = 2'd3
   } bpa_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DOWN,
      ST_CLIMB,
      ST_UP,
      ST_RESP
   } bpa_state_type;

   typedef struct packed {
      logic        req_type;
      logic [10:0] request_size;
      logic [9:0]  page_offset;
   } bpa_request_type;

   typedef struct packed {
      bpa_status_type status;
      logic [9:0]     alloc_offset;
      logic [10:0]    freed_size;
      logic [10:0]    pages_in_use;
   } bpa_result_type;

   function automatic logic is_pow2(input logic [10:0] x);
      return (x != 11'd0) && ((x & (x - 11'd1)) == 11'd0);
   endfunction

endpackage

`default_nettype wire

### hdl/bpa_if.sv
// Request and response channel interfaces of the buddy page allocator.
`default_nettype none

interface bpa_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [10:0] request_size;
   logic [9:0]  page_offset;

   modport source (output valid, output req_type, output request_size,
                   output page_offset, input ready);
   modport sink   (input valid, input req_type, input request_size,
                   input page_offset, output ready);
endinterface

interface bpa_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [9:0]  alloc_offset;
   logic [10:0] freed_size;
   logic [10:0] pages_in_use;

   modport source (output valid, output status, output alloc_offset,
                   output freed_size, output pages_in_use, input ready);
   modport sink   (input valid, input status, input alloc_offset,
                   input freed_size, input pages_in_use, output ready);
endinterface

`default_nettype wire

### hdl/bpa_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none

module bpa_ram #(
   parameter int unsigned WIDTH = 11,
   parameter int unsigned DEPTH = 2047,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### hdl/bpa_engine.sv
// Tree walker: clearing pass, descent, climb and maxima update over the tree RAM.
`default_nettype none

module bpa_engine #(
   parameter int unsigned PAGES = bpa_pkg::PAGES_DEFAULT,
   localparam int unsigned PW = $clog2(PAGES),
   localparam int unsigned LW = PW + 1,
   localparam int unsigned NW = PW + 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire bpa_pkg::bpa_request_type req,
   output logic                          res_valid,
   input  wire logic                     res_ready,
   output bpa_pkg::bpa_result_type       res,
   output logic                          mem_we,
   output logic [NW-1:0]                 mem_waddr,
   output logic [LW-1:0]                 mem_wdata,
   output logic [NW-1:0]                 mem_raddr,
   input  wire logic [LW-1:0]            mem_rdata
);

   localparam int unsigned CW = (LW > 11) ? LW : 11;

   function automatic logic [NW-1:0] sibling(input logic [NW-1:0] n);
      return n[0] ? n + 1'b1 : n - 1'b1;
   endfunction

   bpa_pkg::bpa_state_type  state_ff, state_in;
   bpa_pkg::bpa_status_type status_ff, status_in;
   logic [NW-1:0] idx_ff, idx_in;
   logic [LW-1:0] nsz_ff, nsz_in;
   logic [LW-1:0] size_ff, size_in;
   logic [PW-1:0] off_ff, off_in;
   logic [LW-1:0] curval_ff, curval_in;
   logic [NW:0]   bnd_ff, bnd_in;
   logic [LW-1:0] freed_ff, freed_in;
   logic [LW-1:0] count_ff, count_in;
   logic [LW-1:0] root_ff, root_in;
   logic          free_ff, free_in;

   logic [NW-1:0] lc, down_idx, par, leaf;
   logic          go_left, clr_hit;
   logic [LW-1:0] half, dbl, maxv, upv, count_sub, clr_val;
   logic [LW:0]   sum;
   logic [PW-1:0] down_off;

   assign lc        = {idx_ff[NW-2:0], 1'b1};
   assign go_left   = mem_rdata >= size_ff;
   assign down_idx  = go_left ? lc : lc + 1'b1;
   assign half      = nsz_ff >> 1;
   assign dbl       = nsz_ff << 1;
   assign down_off  = go_left ? off_ff : off_ff + PW'(half);
   assign par       = (idx_ff - 1'b1) >> 1;
   assign leaf      = NW'(req.page_offset) + NW'(PAGES - 1);
   assign maxv      = (curval_ff > mem_rdata) ? curval_ff : mem_rdata;
   assign sum       = {1'b0, curval_ff} + {1'b0, mem_rdata};
   // buddies merge only when both halves are wholly free
   assign upv       = (free_ff && sum == {1'b0, dbl}) ? dbl : maxv;
   assign count_sub = (count_ff > nsz_ff) ? count_ff - nsz_ff : '0;
   assign clr_hit   = ({1'b0, idx_ff} + 1'b1) == bnd_ff;
   assign clr_val   = clr_hit ? half : nsz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpa_pkg::ST_CLEAR;
         idx_ff   <= '0;
         nsz_ff   <= LW'(PAGES);
         bnd_ff   <= (NW+1)'(2);
         root_ff  <= LW'(PAGES);
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         nsz_ff   <= nsz_in;
         bnd_ff   <= bnd_in;
         root_ff  <= root_in;
         count_ff <= count_in;
      end
      status_ff <= status_in;
      size_ff   <= size_in;
      off_ff    <= off_in;
      curval_ff <= curval_in;
      freed_ff  <= freed_in;
      free_ff   <= free_in;
   end

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      idx_in    = idx_ff;
      nsz_in    = nsz_ff;
      size_in   = size_ff;
      off_in    = off_ff;
      curval_in = curval_ff;
      bnd_in    = bnd_ff;
      freed_in  = freed_ff;
      count_in  = count_ff;
      root_in   = root_ff;
      free_in   = free_ff;
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = '0;
      mem_raddr = '0;
      req_ready = 1'b0;
      res_valid = 1'b0;

      case (state_ff)
         bpa_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = clr_val;
            nsz_in    = clr_val;
            bnd_in    = clr_hit ? bnd_ff << 1 : bnd_ff;
            if (idx_ff == NW'(2 * PAGES - 2)) begin
               idx_in   = '0;
               state_in = bpa_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         bpa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               off_in   = '0;
               freed_in = '0;
               free_in  = req.req_type;
               if (req.req_type == bpa_pkg::REQ_ALLOC) begin
                  size_in = LW'(req.request_size);
                  if (!bpa_pkg::is_pow2(req.request_size)) begin
                     status_in = bpa_pkg::STAT_BAD_SIZE;
                     state_in  = bpa_pkg::ST_RESP;
                  end else if (CW'(req.request_size) > CW'(root_ff)) begin
                     status_in = bpa_pkg::STAT_NO_SPACE;
                     state_in  = bpa_pkg::ST_RESP;
                  end else if (LW'(req.request_size) == LW'(PAGES)) begin
                     // whole pool in one block
                     mem_we    = 1'b1;
                     mem_waddr = '0;
                     root_in   = '0;
                     count_in  = count_ff + LW'(req.request_size);
                     status_in = bpa_pkg::STAT_OK;
                     state_in  = bpa_pkg::ST_RESP;
                  end else begin
                     idx_in    = '0;
                     nsz_in    = LW'(PAGES);
                     mem_raddr = NW'(1);
                     state_in  = bpa_pkg::ST_DOWN;
                  end
               end else begin
                  if (CW'(req.page_offset) >= CW'(PAGES)) begin
                     status_in = bpa_pkg::STAT_NOT_ALLOC;
                     state_in  = bpa_pkg::ST_RESP;
                  end else begin
                     idx_in    = leaf;
                     nsz_in    = LW'(1);
                     mem_raddr = leaf;
                     state_in  = bpa_pkg::ST_CLIMB;
                  end
               end
            end
         end

         bpa_pkg::ST_DOWN: begin
            idx_in = down_idx;
            nsz_in = half;
            off_in = down_off;
            if (half == size_ff) begin
               mem_we    = 1'b1;
               mem_waddr = down_idx;
               mem_wdata = '0;
               curval_in = '0;
               count_in  = count_ff + size_ff;
               mem_raddr = sibling(down_idx);
               state_in  = bpa_pkg::ST_UP;
            end else begin
               mem_raddr = {down_idx[NW-2:0], 1'b1};
            end
         end

         bpa_pkg::ST_CLIMB: begin
            if (mem_rdata == '0) begin
               mem_we    = 1'b1;
               mem_wdata = nsz_ff;
               freed_in  = nsz_ff;
               curval_in = nsz_ff;
               count_in  = count_sub;
               if (idx_ff == '0) begin
                  root_in   = nsz_ff;
                  status_in = bpa_pkg::STAT_OK;
                  state_in  = bpa_pkg::ST_RESP;
               end else begin
                  mem_raddr = sibling(idx_ff);
                  state_in  = bpa_pkg::ST_UP;
               end
            end else if (idx_ff == '0) begin
               status_in = bpa_pkg::STAT_NOT_ALLOC;
               state_in  = bpa_pkg::ST_RESP;
            end else begin
               idx_in    = par;
               nsz_in    = dbl;
               mem_raddr = par;
            end
         end

         bpa_pkg::ST_UP: begin
            mem_we    = 1'b1;
            mem_waddr = par;
            mem_wdata = upv;
            idx_in    = par;
            curval_in = upv;
            nsz_in    = dbl;
            if (par == '0) begin
               root_in   = upv;
               status_in = bpa_pkg::STAT_OK;
               state_in  = bpa_pkg::ST_RESP;
            end else begin
               mem_raddr = sibling(par);
            end
         end

         bpa_pkg::ST_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = bpa_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bpa_pkg::ST_IDLE;
         end
      endcase
   end

   assign res.status       = status_ff;
   assign res.alloc_offset = 10'(off_ff);
   assign res.freed_size   = 11'(freed_ff);
   assign res.pages_in_use = 11'(count_ff);

endmodule

`default_nettype wire

### hdl/buddy_page_allocator.sv
// Top level of the binary buddy page allocator: engine, tree RAM and response register.
`default_nettype none

// Binary buddy allocator over PAGES pages (a power of two, 2 to 1024). A tree
// of 2*PAGES-1 nodes, held in one RAM with a registered read, keeps the
// longest free run under each node. After reset a clearing pass writes every
// node's full size, and no request is taken until it ends. Requests are served
// one at a time and the RAM read port sets the pace of the walk, one tree
// level at a time. An allocation walks down from the root (descent), then
// updates the maxima back up to the root; bad size and no space are answered
// without a tree walk. A free climbs from the leaf to the allocated node and
// then updates the maxima from there to the root, so it visits every level
// once, also when the offset turns out not to be allocated. The response sits
// in an output register, so a new request is taken while the last response
// waits.
module buddy_page_allocator #(
   parameter int unsigned PAGES = bpa_pkg::PAGES_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   bpa_req_if.sink  req_ch,
   bpa_rsp_if.source rsp_ch
);

   localparam int unsigned PW = $clog2(PAGES);
   localparam int unsigned LW = PW + 1;
   localparam int unsigned NW = PW + 1;

   bpa_pkg::bpa_request_type req;
   bpa_pkg::bpa_result_type  res, rsp_ff, rsp_in;
   logic                     res_valid, res_ready;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic          mem_we;
   logic [NW-1:0] mem_waddr, mem_raddr;
   logic [LW-1:0] mem_wdata, mem_rdata;

   assign req.req_type     = req_ch.req_type;
   assign req.request_size = req_ch.request_size;
   assign req.page_offset  = req_ch.page_offset;

   bpa_engine #(.PAGES(PAGES)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req       (req),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   // longest free run per node
   bpa_ram #(.WIDTH(LW), .DEPTH(2 * PAGES - 1)) u_tree (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // output register: filled when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_ff.status;
   assign rsp_ch.alloc_offset = rsp_ff.alloc_offset;
   assign rsp_ch.freed_size   = rsp_ff.freed_size;
   assign rsp_ch.pages_in_use = rsp_ff.pages_in_use;

   // one request at a time: the engine is busy right after taking one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request taken while previous one in flight");

   // a free only ever releases a whole power-of-two block, and only on success
   a_freed_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.freed_size == 11'd0 ||
                        (rsp_ff.status == bpa_pkg::STAT_OK && $onehot(rsp_ff.freed_size))))
      else $error("freed size not a successful power-of-two block");

   // page count cannot exceed the pool
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (PAGES > 1024 || rsp_ff.pages_in_use <= 11'(PAGES)))
      else $error("pages in use exceeds pool size");

endmodule

`default_nettype wire
